// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file tbp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert an implication in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== src/tbp_pkg.sv =====
// ---------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants of the tournament branch predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tbp_pkg;
   localparam logic [1:0] MODE_STATIC = 2'd0;
   localparam logic [1:0] MODE_GSHARE = 2'd1;
   localparam logic [1:0] MODE_TOURN  = 2'd2;
   localparam logic [1:0] MODE_CUSTOM = 2'd3;
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_GHIST = 2'd1;
   localparam logic [1:0] REG_LHIST = 2'd2;
   localparam logic [1:0] REG_PCIDX = 2'd3;
   localparam logic [3:0] CUSTOM_GBITS = 4'd12;
   localparam logic [3:0] CUSTOM_LBITS = 4'd11;
   localparam logic [3:0] CUSTOM_PBITS = 4'd11;
   localparam logic [3:0] CNT_INIT_STD = 4'd1;
   localparam logic [3:0] CNT_INIT_CUS = 4'd7;
   localparam logic [3:0] CNT_TOP_STD  = 4'd3;
   localparam logic [3:0] CNT_TOP_CUS  = 4'd15;
   localparam logic [3:0] CNT_THR_STD  = 4'd2;
   localparam logic [3:0] CNT_THR_CUS  = 4'd8;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear;     // clear sweep step
      logic capture;   // take the input beat
      logic read;      // launch table reads
      logic finish;    // decide and write back
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_done;
   } sts_type;

   function automatic logic [3:0] bump(input logic [3:0] c, input logic up,
                                       input logic [3:0] top);
      if (up) bump = (c < top) ? c + 4'd1 : c;
      else    bump = (c != 4'd0) ? c - 4'd1 : c;
   endfunction

   function automatic logic [3:0] clip(input logic [3:0] w, input logic [4:0] maxw);
      if (w == 4'd0) clip = 4'd1;
      else if ({1'b0, w} > maxw) clip = maxw[3:0];
      else clip = w;
   endfunction
endpackage

// ===== src/tbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// tbp_ctrl
// Sequencer: clearing sweep, then capture, read and finish for each beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_write,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             rsp_busy,
   input  tbp_pkg::sts_type sts,
   output tbp_pkg::cmd_type cmd
);
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Advance the sequence; any register write restarts the sweep.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && !rsp_busy) state_in = ST_READ;
         ST_READ:  state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
      if (cfg_write) state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Drop the sweep step on a register write so the sweep starts over.
   assign req_stall   = !(state_ff == ST_IDLE) || rsp_busy;
   assign cmd.clear   = (state_ff == ST_CLEAR) && !cfg_write;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid && !rsp_busy;
   assign cmd.read    = (state_ff == ST_READ);
   assign cmd.finish  = (state_ff == ST_DONE);
endmodule

// ===== src/tbp_dpath.sv =====
// ---------------------------------------------------------------------------
// tbp_dpath
// Tables, histories and counter logic of the predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbp_dpath #(
   parameter int GHIST_MAX = 13,
   parameter int LHIST_MAX = 11,
   parameter int PCIDX_MAX = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  tbp_pkg::cmd_type cmd,
   output tbp_pkg::sts_type sts,
   input  logic [1:0]       mode,
   input  logic [3:0]       ghist_bits,
   input  logic [3:0]       lhist_bits,
   input  logic [3:0]       pcidx_bits,
   input  logic             req_op,
   input  logic [31:0]      req_pc,
   input  logic             req_outcome,
   output logic             res_valid,
   output logic             res_taken
);
   localparam int CMAX = (GHIST_MAX > LHIST_MAX) ?
      ((GHIST_MAX > PCIDX_MAX) ? GHIST_MAX : PCIDX_MAX) :
      ((LHIST_MAX > PCIDX_MAX) ? LHIST_MAX : PCIDX_MAX);

   logic [3:0] gcnt_mem [2**GHIST_MAX];
   logic [3:0] ccnt_mem [2**GHIST_MAX];
   logic [3:0] lcnt_mem [2**LHIST_MAX];
   logic [LHIST_MAX-1:0] lhist_mem [2**PCIDX_MAX];

   logic [CMAX:0]          clr_ff;
   logic [GHIST_MAX-1:0]   ghist_ff;
   logic                   op_ff, out_ff;
   logic [PCIDX_MAX-1:0]   pi_ff;
   logic [GHIST_MAX-1:0]   gi_ff;
   logic [LHIST_MAX-1:0]   li_ff;
   logic [3:0]             gc_ff, cc_ff, lc_ff;
   logic [3:0]             gb, lb, pb, init, top, thr;
   logic [GHIST_MAX-1:0]   gmask, gi_in;
   logic [LHIST_MAX-1:0]   lmask, li_in;
   logic [PCIDX_MAX-1:0]   pmask;
   logic                   gpred, lpred, custom;
   logic [3:0]             gc_nx, cc_nx, lc_nx;
   logic [GHIST_MAX-1:0]   ghist_nx;

   // Effective widths, masks and counter limits for the active mode.
   always_comb begin
      custom = (mode == tbp_pkg::MODE_CUSTOM);
      gb = tbp_pkg::clip(custom ? tbp_pkg::CUSTOM_GBITS : ghist_bits, 5'(GHIST_MAX));
      lb = tbp_pkg::clip(custom ? tbp_pkg::CUSTOM_LBITS : lhist_bits, 5'(LHIST_MAX));
      pb = tbp_pkg::clip(custom ? tbp_pkg::CUSTOM_PBITS : pcidx_bits, 5'(PCIDX_MAX));
      gmask = GHIST_MAX'(({{GHIST_MAX{1'b0}}, 1'b1} << gb) - 1'b1);
      lmask = LHIST_MAX'(({{LHIST_MAX{1'b0}}, 1'b1} << lb) - 1'b1);
      pmask = PCIDX_MAX'(({{PCIDX_MAX{1'b0}}, 1'b1} << pb) - 1'b1);
      init = custom ? tbp_pkg::CNT_INIT_CUS : tbp_pkg::CNT_INIT_STD;
      top  = custom ? tbp_pkg::CNT_TOP_CUS : tbp_pkg::CNT_TOP_STD;
      thr  = custom ? tbp_pkg::CNT_THR_CUS : tbp_pkg::CNT_THR_STD;
   end

   // Clear sweep counter over the largest table.
   assign sts.clear_done = clr_ff[CMAX];
   always_ff @(posedge clock) begin
      if (reset || !cmd.clear) clr_ff <= '0;
      else if (!clr_ff[CMAX])  clr_ff <= clr_ff + 1'b1;
   end

   // Global history: cleared by the sweep, shifted on a train beat outside static mode.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) ghist_ff <= '0;
      else if (cmd.finish && op_ff == tbp_pkg::OP_TRAIN && mode != tbp_pkg::MODE_STATIC)
         ghist_ff <= ghist_nx;
   end
   assign ghist_nx = ({ghist_ff[GHIST_MAX-2:0], out_ff}) & gmask;

   // Capture the beat and form the table indexes.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         out_ff <= req_outcome;
         pi_ff  <= req_pc[PCIDX_MAX-1:0] & pmask;
         gi_ff  <= (mode == tbp_pkg::MODE_GSHARE) ?
                   ((req_pc[GHIST_MAX-1:0] ^ ghist_ff) & gmask) : (ghist_ff & gmask);
      end
   end

   // Registered table reads; local history read leads the local counter.
   always_ff @(posedge clock) begin
      if (cmd.capture) li_ff <= lhist_mem[req_pc[PCIDX_MAX-1:0] & pmask] & lmask;
      if (cmd.read) begin
         gc_ff <= gcnt_mem[gi_ff];
         cc_ff <= ccnt_mem[gi_ff];
         lc_ff <= lcnt_mem[li_ff];
      end
   end

   // Decide, then compute write-back values.
   always_comb begin
      gpred = gc_ff >= thr;
      lpred = lc_ff >= thr;
      gc_nx = tbp_pkg::bump(gc_ff, out_ff, top);
      lc_nx = tbp_pkg::bump(lc_ff, out_ff, top);
      cc_nx = cc_ff;
      if (gpred == out_ff && lpred != out_ff) cc_nx = tbp_pkg::bump(cc_ff, 1'b1, top);
      else if (lpred == out_ff && gpred != out_ff) cc_nx = tbp_pkg::bump(cc_ff, 1'b0, top);
      li_in = ({li_ff[LHIST_MAX-2:0], out_ff}) & lmask;
      gi_in = gi_ff;
   end

   // Table writes: sweep entries, or write back a train beat.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         gcnt_mem[clr_ff[GHIST_MAX-1:0]]  <= init;
         ccnt_mem[clr_ff[GHIST_MAX-1:0]]  <= init;
         lcnt_mem[clr_ff[LHIST_MAX-1:0]]  <= init;
         lhist_mem[clr_ff[PCIDX_MAX-1:0]] <= '0;
      end else if (cmd.finish && op_ff == tbp_pkg::OP_TRAIN) begin
         if (mode != tbp_pkg::MODE_STATIC) gcnt_mem[gi_in] <= gc_nx;
         if (mode == tbp_pkg::MODE_TOURN || mode == tbp_pkg::MODE_CUSTOM) begin
            ccnt_mem[gi_in]  <= cc_nx;
            lcnt_mem[li_ff]  <= lc_nx;
            lhist_mem[pi_ff] <= li_in;
         end
      end
   end

   // Result of a predict beat.
   assign res_valid = cmd.finish && op_ff == tbp_pkg::OP_PREDICT;
   always_comb begin
      case (mode)
         tbp_pkg::MODE_STATIC: res_taken = 1'b1;
         tbp_pkg::MODE_GSHARE: res_taken = gc_ff >= tbp_pkg::CNT_THR_STD;
         default:              res_taken = (cc_ff >= thr) ? gpred : lpred;
      endcase
   end
endmodule

// ===== src/tournament_branch_predictor.sv =====
// ---------------------------------------------------------------------------
// tournament_branch_predictor
// Static / gshare / tournament / custom conditional branch predictor.
// ---------------------------------------------------------------------------
// A train beat holds the request side through its capture, table read, and
// decide and write back states; the read state follows from the registered
// reads of the counter tables. A predict beat yields one response beat from
// an output register, and the request side stays stalled until that beat
// leaves, also while the response is stalled. After reset and after any
// register write a clearing sweep over the largest table rewrites every
// table; a write during the sweep starts it over, and requests are stalled
// during it.
`timescale 1ns / 1ps
module tournament_branch_predictor #(
   parameter int GHIST_MAX = 13,
   parameter int LHIST_MAX = 11,
   parameter int PCIDX_MAX = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_pc,
   input  logic        req_outcome,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_taken,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   tbp_pkg::cmd_type cmd;
   tbp_pkg::sts_type sts;
   logic [1:0] mode_ff;
   logic [3:0] ghist_ff, lhist_ff, pcidx_ff;
   logic       cfg_write, res_valid, res_taken;
   logic       rv_ff, rt_ff;

   // Configuration registers.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tbp_pkg::MODE_STATIC;
         ghist_ff <= 4'd13;
         lhist_ff <= 4'd10;
         pcidx_ff <= 4'd10;
      end else if (cfg_write) begin
         case (paddr[3:2])
            tbp_pkg::REG_MODE:  mode_ff  <= pwdata[1:0];
            tbp_pkg::REG_GHIST: ghist_ff <= pwdata[3:0];
            tbp_pkg::REG_LHIST: lhist_ff <= pwdata[3:0];
            tbp_pkg::REG_PCIDX: pcidx_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (paddr[3:2])
         tbp_pkg::REG_MODE:  prdata = {30'd0, mode_ff};
         tbp_pkg::REG_GHIST: prdata = {28'd0, ghist_ff};
         tbp_pkg::REG_LHIST: prdata = {28'd0, lhist_ff};
         tbp_pkg::REG_PCIDX: prdata = {28'd0, pcidx_ff};
         default:            prdata = 32'd0;
      endcase
   end

   tbp_ctrl u_ctrl (
      .clock, .reset, .cfg_write, .req_valid, .req_stall,
      .rsp_busy(rv_ff), .sts, .cmd
   );

   tbp_dpath #(.GHIST_MAX(GHIST_MAX), .LHIST_MAX(LHIST_MAX), .PCIDX_MAX(PCIDX_MAX))
   u_dpath (
      .clock, .reset, .cmd, .sts, .mode(mode_ff), .ghist_bits(ghist_ff),
      .lhist_bits(lhist_ff), .pcidx_bits(pcidx_ff), .req_op, .req_pc,
      .req_outcome, .res_valid, .res_taken
   );

   // Response output register; hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (res_valid) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (res_valid) rt_ff <= res_taken;
   end
   assign rsp_valid = rv_ff;
   assign rsp_taken = rt_ff;
endmodule

// ===== src/tbp_checker.sv =====
// ---------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the predictor, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_taken,
   input logic pready
);
   `ASSERT_IMPLY(a_pready, clock, reset, 1'b1, pready, "pready low")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_taken), "stalled beat changed")
   `ASSERT_IMPLY(a_busy_stall, clock, reset, rsp_valid, req_stall, "request taken while response pending")
   `ASSERT_NEXT(a_one_beat, clock, reset, req_valid && !req_stall, req_stall, "back-to-back request accepted")
endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_taken, .pready
);
